### rtl/tmma_pkg.sv
package tmma_pkg;

    localparam int VERTICES   = 4;
    localparam int DIMENSIONS = 3;
    localparam int VIW        = $clog2(VERTICES);

    localparam int CW    = 24;
    localparam int VSW   = 26;
    localparam int EW    = CW + 1;
    localparam int PW    = 2 * EW;
    localparam int CRW   = PW + 1;
    localparam int CLO   = 26;
    localparam int DLW   = EW + CLO + 1;
    localparam int DHW   = EW + CRW - CLO;
    localparam int DETW  = 78;
    localparam int LIMB  = DETW / 3;
    localparam int VPW   = LIMB + VSW;
    localparam int MSW   = 104;
    localparam int RSH   = 27;
    localparam int EMW   = 48;
    localparam int TW    = 64;
    localparam int DIVW  = 56;
    localparam int DIVB  = 8;
    localparam int DIV_STEPS = DIVW / DIVB;
    localparam int DCW   = $clog2(DIV_STEPS);

    localparam int QDEPTH_DEF = 2;

    localparam logic [2:0]     DIVISOR     = 3'd3;
    localparam logic [MSW-1:0] ROUND_ADD   = MSW'(3) << (RSH - 1);
    localparam logic [MSW-1:0] SAT_POS_LIM = MSW'(3) << (EMW - 1);
    localparam logic [MSW-1:0] SAT_NEG_LIM = (MSW'(3) << (EMW - 1)) + MSW'(3);

    localparam logic signed [EMW-1:0] EM_MAX = {1'b0, {(EMW-1){1'b1}}};
    localparam logic signed [EMW-1:0] EM_MIN = {1'b1, {(EMW-1){1'b0}}};
    localparam logic signed [TW-1:0]  TOT_MAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0]  TOT_MIN = {1'b1, {(TW-1){1'b0}}};

    typedef struct packed {
        logic signed [CW-1:0] x_coord;
        logic signed [CW-1:0] y_coord;
        logic signed [CW-1:0] z_coord;
        logic signed [CW-1:0] nodal_value;
        logic                 end_of_mesh;
    } t_vertex;

    typedef struct packed {
        logic signed [EMW-1:0] element_mass;
        logic signed [TW-1:0]  total_mass;
        logic                  final_element;
    } t_result;

    typedef struct packed {
        logic [VERTICES-1:0][DIMENSIONS-1:0][CW-1:0] coords;
        logic signed [VSW-1:0]                       value_sum;
        logic                                        last;
    } t_job;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CROSS,
        ST_CSUM,
        ST_DOT,
        ST_DSUM,
        ST_ABS,
        ST_VMUL,
        ST_MSUM,
        ST_SAT,
        ST_DIV,
        ST_OUT
    } t_back_state;

endpackage

### rtl/tmma_front.sv
module tmma_front
    import tmma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_vertex i_vertex,
    input  logic    i_q_full,
    output logic    o_job_push,
    output t_job    o_job
);

    logic [VIW-1:0]                              r_vidx;
    logic [VERTICES-2:0][DIMENSIONS-1:0][CW-1:0] r_held;
    logic signed [VSW-1:0]                       r_value_sum;
    logic signed [VSW-1:0]                       n_value_sum;
    logic                                        w_accept;
    logic                                        w_closing;

    assign w_accept    = i_push & ~i_q_full;
    assign w_closing   = (r_vidx == VIW'(VERTICES - 1));
    assign n_value_sum = r_value_sum
                       + {{(VSW-CW){i_vertex.nodal_value[CW-1]}}, i_vertex.nodal_value};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vidx      <= '0;
            r_value_sum <= '0;
        end else if (w_accept) begin
            if (w_closing) begin
                r_vidx      <= '0;
                r_value_sum <= '0;
            end else begin
                r_vidx      <= r_vidx + VIW'(1);
                r_value_sum <= n_value_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_closing) begin
            r_held[r_vidx[VIW-1:0]][0] <= i_vertex.x_coord;
            r_held[r_vidx[VIW-1:0]][1] <= i_vertex.y_coord;
            r_held[r_vidx[VIW-1:0]][2] <= i_vertex.z_coord;
        end
    end

    always_comb begin
        o_job.coords[VERTICES-2:0]  = r_held;
        o_job.coords[VERTICES-1][0] = i_vertex.x_coord;
        o_job.coords[VERTICES-1][1] = i_vertex.y_coord;
        o_job.coords[VERTICES-1][2] = i_vertex.z_coord;
        o_job.value_sum             = n_value_sum;
        o_job.last                  = i_vertex.end_of_mesh;
    end

    assign o_job_push = w_accept & w_closing;

endmodule

### rtl/tmma_queue.sv
module tmma_queue
    import tmma_pkg::*;
#(
    parameter int DEPTH = QDEPTH_DEF
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_q_stat o_stat,
    output t_job    o_job
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CNTW-1:0] r_count;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= f_next(r_wr);
            end
            if (i_pop) begin
                r_rd <= f_next(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNTW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNTW'(DEPTH));

endmodule

### rtl/tmma_back.sv
module tmma_back
    import tmma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    input  t_job    i_job,
    output logic    o_q_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_back_state r_state;
    t_back_state n_state;

    logic signed [EW-1:0]   r_e [DIMENSIONS][DIMENSIONS];
    logic                   r_neg;
    logic                   r_last;
    logic [VSW-1:0]         r_vmag;
    logic signed [PW-1:0]   r_p [6];
    logic signed [CRW-1:0]  r_c [DIMENSIONS];
    logic signed [DLW-1:0]  r_dlo [DIMENSIONS];
    logic signed [DHW-1:0]  r_dhi [DIMENSIONS];
    logic signed [DETW-1:0] r_det;
    logic [DETW-1:0]        r_dmag;
    logic [VPW-1:0]         r_vp [3];
    logic [MSW-1:0]         r_msum;
    logic                   r_sat;
    logic [DIVW-1:0]        r_dvd;
    logic [DIVW-1:0]        r_quo;
    logic [1:0]             r_rem;
    logic [DCW-1:0]         r_div_cnt;
    logic                   r_out_valid;
    t_result                r_out;
    logic signed [TW-1:0]   r_total;

    logic                   w_out_load;
    logic                   w_out_free;
    logic signed [DETW-1:0] w_det;
    logic [MSW-1:0]         w_sh;
    logic [DIVB-1:0]        w_qbits;
    logic [1:0]             w_rem;
    logic [EMW-1:0]         w_q;
    logic signed [EMW-1:0]  w_em;
    logic signed [TW:0]     w_tsum;
    logic signed [TW-1:0]   w_tsat;

    assign w_out_free = !r_out_valid || i_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_q_pop    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_pop = 1'b1;
                    n_state = ST_CROSS;
                end
            end
            ST_CROSS: n_state = ST_CSUM;
            ST_CSUM:  n_state = ST_DOT;
            ST_DOT:   n_state = ST_DSUM;
            ST_DSUM:  n_state = ST_ABS;
            ST_ABS:   n_state = ST_VMUL;
            ST_VMUL:  n_state = ST_MSUM;
            ST_MSUM:  n_state = ST_SAT;
            ST_SAT:   n_state = ST_DIV;
            ST_DIV: begin
                if (r_div_cnt == DCW'(DIV_STEPS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_det = '0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            w_det = w_det + (DETW'(r_dhi[d]) <<< CLO) + DETW'(r_dlo[d]);
        end
    end

    assign w_sh = r_msum >> RSH;

    always_comb begin
        logic [2:0] cur;
        w_rem   = r_rem;
        w_qbits = '0;
        for (int j = 0; j < DIVB; j++) begin
            cur = {w_rem, r_dvd[DIVW-1-j]};
            if (cur >= DIVISOR) begin
                w_qbits[DIVB-1-j] = 1'b1;
                cur               = cur - DIVISOR;
            end
            w_rem = cur[1:0];
        end
    end

    always_comb begin
        w_q = r_quo[EMW-1:0];
        if (r_sat) begin
            w_em = r_neg ? EM_MIN : EM_MAX;
        end else begin
            w_em = r_neg ? $signed(-w_q) : $signed(w_q);
        end
        w_tsum = {r_total[TW-1], r_total} + {{(TW+1-EMW){w_em[EMW-1]}}, w_em};
        if (w_tsum[TW] != w_tsum[TW-1]) begin
            w_tsat = w_tsum[TW] ? TOT_MIN : TOT_MAX;
        end else begin
            w_tsat = w_tsum[TW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                for (int i = 0; i < DIMENSIONS; i++) begin
                    for (int d = 0; d < DIMENSIONS; d++) begin
                        r_e[i][d] <= EW'($signed(i_job.coords[i+1][d]))
                                   - EW'($signed(i_job.coords[0][d]));
                    end
                end
                r_neg  <= i_job.value_sum[VSW-1];
                r_vmag <= i_job.value_sum[VSW-1] ? VSW'(-i_job.value_sum)
                                                 : VSW'(i_job.value_sum);
                r_last <= i_job.last;
            end
            ST_CROSS: begin
                r_p[0] <= r_e[1][1] * r_e[2][2];
                r_p[1] <= r_e[1][2] * r_e[2][1];
                r_p[2] <= r_e[1][2] * r_e[2][0];
                r_p[3] <= r_e[1][0] * r_e[2][2];
                r_p[4] <= r_e[1][0] * r_e[2][1];
                r_p[5] <= r_e[1][1] * r_e[2][0];
            end
            ST_CSUM: begin
                for (int k = 0; k < DIMENSIONS; k++) begin
                    r_c[k] <= CRW'(r_p[2*k]) - CRW'(r_p[2*k+1]);
                end
            end
            ST_DOT: begin
                for (int d = 0; d < DIMENSIONS; d++) begin
                    r_dlo[d] <= r_e[0][d] * $signed({1'b0, r_c[d][CLO-1:0]});
                    r_dhi[d] <= r_e[0][d] * $signed(r_c[d][CRW-1:CLO]);
                end
            end
            ST_DSUM: r_det <= w_det;
            ST_ABS: begin
                r_dmag <= r_det[DETW-1] ? $unsigned(-r_det) : $unsigned(r_det);
            end
            ST_VMUL: begin
                for (int k = 0; k < 3; k++) begin
                    r_vp[k] <= VPW'(r_dmag[k*LIMB +: LIMB]) * VPW'(r_vmag);
                end
            end
            ST_MSUM: begin
                r_msum <= MSW'(r_vp[0]) + (MSW'(r_vp[1]) << LIMB)
                        + (MSW'(r_vp[2]) << (2 * LIMB)) + ROUND_ADD;
            end
            ST_SAT: begin
                r_sat <= r_neg ? (w_sh >= SAT_NEG_LIM) : (w_sh >= SAT_POS_LIM);
                r_dvd <= w_sh[DIVW-1:0];
                r_quo <= '0;
                r_rem <= '0;
            end
            ST_DIV: begin
                r_dvd <= r_dvd << DIVB;
                r_quo <= {r_quo[DIVW-DIVB-1:0], w_qbits};
                r_rem <= w_rem;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else begin
            if (r_state == ST_DIV) begin
                r_div_cnt <= (r_div_cnt == DCW'(DIV_STEPS - 1)) ? '0
                                                                 : r_div_cnt + DCW'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_total     <= r_last ? '0 : w_tsat;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.element_mass  <= w_em;
            r_out.total_mass    <= w_tsat;
            r_out.final_element <= r_last;
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule

### rtl/tetra_mesh_mass_accumulator_unit.sv
// channel   | handshake        | payload
// ----------+------------------+---------------------------------------------
// vertex in | push / full      | i_vertex : t_vertex (x, y, z, value, end mark)
// result    | empty / pop      | o_result : t_result (element, total, final)
//
// Vertices enter one per cycle while the element queue has room; the fourth
// vertex of an element moves the element into the queue.
// The back sequencer takes each element through ten steps and seven radix-256
// divide-by-three steps, and it pops no new element from the queue until the
// result of the current element is loaded into the output register.
// Reset is synchronous, active low, with no clearing pass. A held result stalls
// only the final step; the queue absorbs the rest, then full stalls the input.
module tetra_mesh_mass_accumulator_unit
    import tmma_pkg::*;
#(
    parameter int QUEUE_DEPTH = QDEPTH_DEF
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    push,
    output logic    full,
    input  t_vertex i_vertex,
    output logic    empty,
    input  logic    pop,
    output t_result o_result
);

    t_q_stat q_stat;
    t_job    front_job;
    t_job    head_job;
    logic    job_push;
    logic    back_pop;
    logic    out_pop;

    assign full    = q_stat.full;
    assign out_pop = pop & ~empty;

    tmma_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_vertex   (i_vertex),
        .i_q_full   (q_stat.full),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    tmma_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (back_pop),
        .o_stat  (q_stat),
        .o_job   (head_job)
    );

    tmma_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (q_stat),
        .i_job    (head_job),
        .o_q_pop  (back_pop),
        .i_pop    (out_pop),
        .o_empty  (empty),
        .o_result (o_result)
    );

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> empty)
        else $error("result present right after reset");

    a_queue_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue reports empty and full together");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_pop |-> !q_stat.empty)
        else $error("sequencer took an element from an empty queue");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !q_stat.full)
        else $error("element written into a full queue");

endmodule
